FILE: hw/rtl/fcm_pkg.sv
// fcm_pkg: shared types, constants and helper functions for the freshness
// counter manager core. Used by fcm_alu and freshness_counter_manager_core.
package fcm_pkg;

  localparam int FV_BITS      = 32;
  localparam int LEN_W        = 6;
  localparam int OP_W         = 3;
  localparam int ID_W         = 4;
  localparam int NUM_IDS_DEF  = 16;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_INC     = 3'd0,
    OP_SET     = 3'd1,
    OP_TXGET   = 3'd2,
    OP_TXTRUNC = 3'd3,
    OP_RXVER   = 3'd4
  } fcm_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_INC,
    S_RXCMP,
    S_RXADD,
    S_RXCHK,
    S_BLEN,
    S_DONE
  } fcm_state_t;

  typedef enum logic [1:0] {
    BL_TX,
    BL_TRUNC,
    BL_RX
  } blen_kind_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SHR1
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [FV_BITS-1:0]   a;
    logic [FV_BITS-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [FV_BITS-1:0]   res;
    logic                 carry;
  } alu_rsp_t;

  // all ones when n reaches the counter width
  function automatic logic [FV_BITS-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [FV_BITS-1:0] one;
    one = FV_BITS'(1);
    if (int'(n) >= FV_BITS) begin
      return {FV_BITS{1'b1}};
    end
    return (one << n) - one;
  endfunction

endpackage

FILE: hw/rtl/fcm_ram.sv
// fcm_ram: generic simple dual-port ram with registered read.
// Standalone, no package dependency.
module fcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/fcm_alu.sv
// fcm_alu: the shared add / subtract / shift-right unit of the core.
// Depends on fcm_pkg for the request and response structs.
module fcm_alu (
  input  fcm_pkg::alu_req_t req,
  output fcm_pkg::alu_rsp_t rsp
);

  logic [fcm_pkg::FV_BITS:0] wide;

  always_comb begin
    wide = '0;
    case (req.op)
      fcm_pkg::ALU_ADD:  wide = {1'b0, req.a} + {1'b0, req.b};
      // top bit is the borrow
      fcm_pkg::ALU_SUB:  wide = {1'b0, req.a} - {1'b0, req.b};
      fcm_pkg::ALU_SHR1: wide = {2'b00, req.a[fcm_pkg::FV_BITS-1:1]};
      default:           wide = '0;
    endcase
    rsp.res   = wide[fcm_pkg::FV_BITS-1:0];
    rsp.carry = wide[fcm_pkg::FV_BITS];
  end

endmodule

FILE: hw/rtl/freshness_counter_manager_core.sv
// freshness_counter_manager_core: per-id freshness counters with increment, set,
// tx get, tx truncated get and rx verify. Uses fcm_pkg, fcm_ram and fcm_alu.
//
// One item is worked at a time: after a beat is taken, in_ready stays low until
// the sequencer has finished it. The counter read goes through the registered
// ram read (address, then registered data), increment and the rx steps each take
// one pass through the shared add/subtract/shift unit, and every significant-bit
// length is found by shifting through that same unit, one bit per cycle. The
// result sits in an output register, so the next beat is taken while it waits
// for out_ready. Counters read as zero after reset through per-entry valid bits;
// no clearing pass is needed.
module freshness_counter_manager_core #(
  parameter int NUM_IDS = fcm_pkg::NUM_IDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fcm_pkg::OP_W-1:0]          opcode,
  input  logic [fcm_pkg::ID_W-1:0]          fv_id,
  input  logic [fcm_pkg::FV_BITS-1:0]       value_in,
  input  logic [fcm_pkg::LEN_W-1:0]         length_in,
  input  logic [fcm_pkg::LEN_W-1:0]         trunc_len,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [fcm_pkg::FV_BITS-1:0]       freshness_out,
  output logic [fcm_pkg::LEN_W-1:0]         freshness_len,
  output logic [fcm_pkg::FV_BITS-1:0]       trunc_out,
  output logic [fcm_pkg::LEN_W-1:0]         trunc_len_out
);

  localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int FVB   = fcm_pkg::FV_BITS;
  localparam int LW    = fcm_pkg::LEN_W;

  fcm_pkg::fcm_state_t  state, state_next;
  fcm_pkg::blen_kind_t  kind, kind_next;

  // captured beat
  logic [fcm_pkg::OP_W-1:0] op_q;
  logic [fcm_pkg::ID_W-1:0] id_q;
  logic [FVB-1:0]           val_q;
  logic [LW-1:0]            len_q;
  logic [LW-1:0]            tl_q;

  // working registers
  logic [FVB-1:0] cnt, cnt_next;
  logic [FVB-1:0] acc, acc_next;
  logic [LW-1:0]  n, n_next;
  logic [FVB-1:0] fo, fo_next;
  logic [LW-1:0]  fl, fl_next;
  logic [FVB-1:0] to, to_next;
  logic [LW-1:0]  tlo, tlo_next;
  logic           st, st_next;

  logic [NUM_IDS-1:0]   vld;
  logic                 vld_set;
  logic                 ram_we;
  logic [FVB-1:0]       ram_wdata;
  logic [FVB-1:0]       ram_rdata;
  logic [IDX_W+fcm_pkg::ID_W-1:0] id_ext;
  logic [IDX_W-1:0]     idx;
  logic                 id_ok;
  logic                 out_load;
  logic                 accept;

  fcm_pkg::alu_req_t alu_req;
  fcm_pkg::alu_rsp_t alu_rsp;

  logic [FVB-1:0] rx_mask;
  logic [FVB-1:0] rx_r;
  logic [LW-1:0]  tx_l;
  logic [FVB-1:0] tx_fo;
  logic [FVB-1:0] tx_to;

  assign id_ext = {{IDX_W{1'b0}}, id_q};
  assign idx    = id_ext[IDX_W-1:0];
  assign id_ok  = (int'(id_q) < NUM_IDS);
  assign accept = in_valid && in_ready;
  assign in_ready = (state == fcm_pkg::S_IDLE);

  assign rx_mask = fcm_pkg::low_mask(tl_q);
  assign rx_r    = val_q & rx_mask;
  assign tx_l    = (len_q <= n) ? len_q : n;
  assign tx_fo   = cnt & fcm_pkg::low_mask(tx_l);
  assign tx_to   = tx_fo & fcm_pkg::low_mask(tl_q);

  fcm_ram #(
    .WIDTH (FVB),
    .DEPTH (NUM_IDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  fcm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcm_pkg::S_IDLE;
      out_valid <= 1'b0;
      vld       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (vld_set) begin
        vld[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= opcode;
      id_q  <= fv_id;
      val_q <= value_in;
      len_q <= length_in;
      tl_q  <= trunc_len;
    end
    kind <= kind_next;
    cnt  <= cnt_next;
    acc  <= acc_next;
    n    <= n_next;
    fo   <= fo_next;
    fl   <= fl_next;
    to   <= to_next;
    tlo  <= tlo_next;
    st   <= st_next;
    if (out_load) begin
      status        <= st;
      freshness_out <= fo;
      freshness_len <= fl;
      trunc_out     <= to;
      trunc_len_out <= tlo;
    end
  end

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    cnt_next    = cnt;
    acc_next    = acc;
    n_next      = n;
    fo_next     = fo;
    fl_next     = fl;
    to_next     = to;
    tlo_next    = tlo;
    st_next     = st;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    vld_set     = 1'b0;
    out_load    = 1'b0;
    alu_req.op  = fcm_pkg::ALU_ADD;
    alu_req.a   = cnt;
    alu_req.b   = '0;

    unique case (state)
      fcm_pkg::S_IDLE: begin
        if (accept) begin
          state_next = fcm_pkg::S_READ;
        end
      end

      fcm_pkg::S_READ: begin
        state_next = fcm_pkg::S_LOAD;
      end

      fcm_pkg::S_LOAD: begin
        cnt_next   = (id_ok && vld[idx]) ? ram_rdata : '0;
        st_next    = 1'b1;
        fo_next    = '0;
        fl_next    = '0;
        to_next    = '0;
        tlo_next   = '0;
        acc_next   = (id_ok && vld[idx]) ? ram_rdata : '0;
        n_next     = '0;
        state_next = fcm_pkg::S_DONE;
        if (id_ok) begin
          unique case (op_q)
            fcm_pkg::OP_INC: begin
              state_next = fcm_pkg::S_INC;
            end
            fcm_pkg::OP_SET: begin
              if (len_q <= fcm_pkg::MAX_LEN) begin
                ram_we    = 1'b1;
                vld_set   = 1'b1;
                ram_wdata = val_q & fcm_pkg::low_mask(len_q);
                st_next   = 1'b0;
              end
            end
            fcm_pkg::OP_TXGET: begin
              if (len_q <= fcm_pkg::MAX_LEN) begin
                kind_next  = fcm_pkg::BL_TX;
                state_next = fcm_pkg::S_BLEN;
              end
            end
            fcm_pkg::OP_TXTRUNC: begin
              if (len_q <= fcm_pkg::MAX_LEN && tl_q <= fcm_pkg::MAX_LEN) begin
                kind_next  = fcm_pkg::BL_TX;
                state_next = fcm_pkg::S_BLEN;
              end
            end
            fcm_pkg::OP_RXVER: begin
              if (tl_q <= fcm_pkg::MAX_LEN) begin
                if (int'(tl_q) >= FVB) begin
                  // received bits cover the whole counter
                  fo_next    = rx_r;
                  state_next = fcm_pkg::S_RXCHK;
                end else begin
                  fo_next    = ((id_ok && vld[idx]) ? ram_rdata : '0) & ~rx_mask;
                  state_next = fcm_pkg::S_RXCMP;
                end
              end
            end
            default: begin
              state_next = fcm_pkg::S_DONE;
            end
          endcase
        end
      end

      fcm_pkg::S_INC: begin
        alu_req.op = fcm_pkg::ALU_ADD;
        alu_req.a  = cnt;
        alu_req.b  = FVB'(1);
        ram_we     = 1'b1;
        vld_set    = 1'b1;
        ram_wdata  = alu_rsp.res;
        st_next    = 1'b0;
        state_next = fcm_pkg::S_DONE;
      end

      fcm_pkg::S_RXCMP: begin
        // borrow means the received bits are above the counter's low bits
        alu_req.op = fcm_pkg::ALU_SUB;
        alu_req.a  = cnt & rx_mask;
        alu_req.b  = rx_r;
        if (alu_rsp.carry) begin
          fo_next    = fo | rx_r;
          state_next = fcm_pkg::S_RXCHK;
        end else begin
          state_next = fcm_pkg::S_RXADD;
        end
      end

      fcm_pkg::S_RXADD: begin
        alu_req.op = fcm_pkg::ALU_ADD;
        alu_req.a  = fo;
        alu_req.b  = FVB'(1) << tl_q;
        fo_next    = alu_rsp.res | rx_r;
        state_next = fcm_pkg::S_RXCHK;
      end

      fcm_pkg::S_RXCHK: begin
        // fresh only if candidate is strictly above the counter
        alu_req.op = fcm_pkg::ALU_SUB;
        alu_req.a  = cnt;
        alu_req.b  = fo;
        st_next    = !alu_rsp.carry;
        acc_next   = fo;
        n_next     = '0;
        kind_next  = fcm_pkg::BL_RX;
        state_next = fcm_pkg::S_BLEN;
      end

      fcm_pkg::S_BLEN: begin
        alu_req.op = fcm_pkg::ALU_SHR1;
        alu_req.a  = acc;
        if (acc != '0) begin
          acc_next = alu_rsp.res;
          n_next   = n + LW'(1);
        end else begin
          state_next = fcm_pkg::S_DONE;
          unique case (kind)
            fcm_pkg::BL_TX: begin
              fo_next = tx_fo;
              fl_next = tx_l;
              st_next = 1'b0;
              if (op_q == fcm_pkg::OP_TXTRUNC) begin
                to_next    = tx_to;
                acc_next   = tx_to;
                n_next     = '0;
                kind_next  = fcm_pkg::BL_TRUNC;
                state_next = fcm_pkg::S_BLEN;
              end
            end
            fcm_pkg::BL_TRUNC: begin
              tlo_next = n;
            end
            fcm_pkg::BL_RX: begin
              fl_next = n;
            end
            default: begin
              state_next = fcm_pkg::S_DONE;
            end
          endcase
        end
      end

      fcm_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = fcm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fcm_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == fcm_pkg::S_DONE))
    else $error("result beat raised outside the done step");

  a_write_good_id: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> id_ok)
    else $error("counter written for an out-of-range id");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (freshness_len <= fcm_pkg::MAX_LEN))
    else $error("freshness length beyond the counter width");

  a_trunc_le_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (trunc_len_out <= freshness_len))
    else $error("truncated length above the full length");
`endif

endmodule
